// ===== rtl/core/slcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// slcdf_pkg
// shared types and constants of the start-of-message / length / checksum
// deframer
// ----------------------------------------------------------------------------
package slcdf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OUT_TDATA_W = 24;  // payload, position, sum_ok, zero fill
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd2;

  // result kinds, carried on tuser
  localparam logic KIND_PASS  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] position;
    logic              last;
    logic              sum_ok;
  } item_t;

endpackage

// ===== rtl/core/slcdf_front.sv =====
// ----------------------------------------------------------------------------
// slcdf_front
// byte classifier: tracks the frame phase, count and running sum and turns
// each accepted byte into zero or one result item
// ----------------------------------------------------------------------------
module slcdf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [slcdf_pkg::BYTE_W-1:0] cfg_wr_data,
  input  logic                         in_take,
  input  logic [slcdf_pkg::BYTE_W-1:0] in_byte,
  output logic                         push,
  output slcdf_pkg::item_t             push_item
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t                       phase_r,  phase_nxt;
  logic [slcdf_pkg::BYTE_W-1:0] marker_r;
  logic [slcdf_pkg::BYTE_W-1:0] sum_r,    sum_nxt;
  logic [slcdf_pkg::BYTE_W-1:0] count_r,  count_nxt;
  logic [slcdf_pkg::BYTE_W-1:0] length_r, length_nxt;
  logic                         fin;

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    push       = 1'b0;
    push_item  = '0;
    fin        = 1'b0;
    if (in_take) begin
      case (phase_r)
        PH_LEN: begin
          length_nxt = in_byte;
          count_nxt  = '0;
          sum_nxt    = in_byte;
          phase_nxt  = PH_BODY;
        end
        PH_BODY: begin
          count_nxt          = count_r + 8'd1;
          sum_nxt            = sum_r + in_byte;
          fin                = (count_nxt == length_r);
          push               = 1'b1;
          push_item.kind     = slcdf_pkg::KIND_FRAME;
          push_item.payload  = in_byte;
          push_item.position = count_r;
          push_item.last     = fin;
          push_item.sum_ok   = fin && (sum_nxt == '0);
          if (fin) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          // idle, and the unused code behaves as idle
          phase_nxt = PH_IDLE;
          if (in_byte == marker_r) begin
            sum_nxt   = '0;
            phase_nxt = PH_LEN;
          end else begin
            push              = 1'b1;
            push_item.kind    = slcdf_pkg::KIND_PASS;
            push_item.payload = in_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      marker_r <= slcdf_pkg::MARKER_RESET;
      sum_r    <= '0;
      count_r  <= '0;
      length_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== rtl/core/slcdf_fifo.sv =====
// ----------------------------------------------------------------------------
// slcdf_fifo
// short item queue between classifier and output stage
// ----------------------------------------------------------------------------
module slcdf_fifo #(
  parameter int unsigned DEPTH = slcdf_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  slcdf_pkg::item_t push_item,
  input  logic             pop,
  output slcdf_pkg::item_t pop_item,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  slcdf_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    fill_r,   fill_nxt;
  logic             do_push, do_pop;

  assign full     = (fill_r == CW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/slcdf_back.sv =====
// ----------------------------------------------------------------------------
// slcdf_back
// output register: pulls items from the queue and holds them on the
// result channel until taken
// ----------------------------------------------------------------------------
module slcdf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  slcdf_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output slcdf_pkg::item_t out_item
);

  logic             valid_r;
  slcdf_pkg::item_t item_r;

  assign q_pop     = !q_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
  end

endmodule

// ===== rtl/core/som_length_checksum_deframer_top.sv =====
// ----------------------------------------------------------------------------
// som_length_checksum_deframer_top
// start-of-message / length / 8-bit sum deframer for a serial byte stream
// ----------------------------------------------------------------------------
// Takes one byte per transfer. While idle, a byte equal to the start marker opens
// a frame and a byte that differs is handed out at once as a passthrough item
// (tuser 0). The byte after the marker is the body length and gives no item;
// then exactly that many body bytes follow, each handed out with its index
// (tuser 1). The final body byte carries tlast and the sum_ok verdict: length
// plus all body bytes must be zero mod 256. A length of zero means 256 bytes.
// Marker and length bytes give no item. The block takes one byte per clock
// while the queue has room and delivers one item per clock while the
// result side is ready; an item is written into the queue when its byte is
// taken, moves from there into the output register once that register is
// free and only then shows on the result channel. A queue of FIFO_DEPTH
// items sits between the classifier and the output register, so in_tready
// falls only when that queue is full because the result side has stalled.
// The start marker resets to 2 and should be written only while no frame is
// in progress.
// ----------------------------------------------------------------------------
module som_length_checksum_deframer_top #(
  parameter int unsigned FIFO_DEPTH = slcdf_pkg::FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: start marker
  input  logic                              cfg_wr_en,
  input  logic [slcdf_pkg::BYTE_W-1:0]      cfg_wr_data,
  // byte input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [slcdf_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slcdf_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload,
                                                         // [15:8] position,
                                                         // [16] sum_ok, rest 0
  output logic                              out_tlast,  // last body byte
  output logic                              out_tuser   // kind: 0 pass, 1 frame
);

  logic             in_take;
  logic             push;
  slcdf_pkg::item_t push_item;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  slcdf_pkg::item_t q_item;
  slcdf_pkg::item_t out_item;

  // a byte is taken whenever the queue has room for a possible item
  assign in_tready = !q_full;
  assign in_take   = in_tvalid && in_tready;

  // front: phase tracking, count and running sum
  slcdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_take    (in_take),
    .in_byte    (in_tdata),
    .push       (push),
    .push_item  (push_item)
  );

  // decoupling queue
  slcdf_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (q_pop),
    .pop_item (q_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: output register toward the result channel
  slcdf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (out_item)
  );

  // pack result fields, lowest bit first
  assign out_tdata = {7'd0, out_item.sum_ok, out_item.position, out_item.payload};
  assign out_tlast = out_item.last;
  assign out_tuser = out_item.kind;

endmodule

// ===== rtl/core/slcdf_chk.sv =====
// ----------------------------------------------------------------------------
// slcdf_chk
// port-level checks on the result channel of the deframer
// ----------------------------------------------------------------------------
module slcdf_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [slcdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast,
  input logic                              out_tuser
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // only frame bytes end a frame
  a_last_is_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == slcdf_pkg::KIND_FRAME)
    else $error("tlast on passthrough item");

  // passthrough items carry zero position and verdict
  a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == slcdf_pkg::KIND_PASS |->
      out_tdata[16:8] == 9'd0 && !out_tlast)
    else $error("passthrough item has frame fields set");

  // verdict only on the final byte, fill bits zero
  a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast || !out_tdata[16]) && out_tdata[23:17] == 7'd0)
    else $error("sum_ok outside final byte or fill bits set");

endmodule

bind som_length_checksum_deframer_top slcdf_chk u_slcdf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

// ===== tb/som_length_checksum_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_length_checksum_deframer_top_tb
// self-checking bench for the start-of-message / length / checksum deframer
// ----------------------------------------------------------------------------
// Feeds serial bytes into the byte stream and checks every result item
// against an in-bench model or typed table rows. A short directed table covers
// passthrough extremes, marker bytes inside frames, good and bad sums and
// one-byte frames. Long frames (length 0 means 256 bytes, and length 255)
// follow. Then random traffic of mostly well-formed frames mixed with noise
// and cut-off frames runs under several start marker values, the extremes
// among them. Sides may idle in short random bursts, except in the last part.
// ----------------------------------------------------------------------------
module som_length_checksum_deframer_top_tb;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;     // two pipeline stages plus margin
  localparam int SEG_ITEMS     = 110;   // random bytes per marker setting
  localparam int NUM_SEGS      = 5;
  localparam int DIR_ROWS      = 23;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_CHECKED,  // expectation from the deframer model
    ROW_SILENT,   // marker or length byte, no item expected
    ROW_TYPED     // expectation typed into the table
  } row_kind_t;

  typedef struct {
    row_kind_t        how;
    logic [7:0]       data;
    slcdf_pkg::item_t want;
  } dir_row_t;

  // receive state of the deframer model
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_BODY
  } deframe_phase_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [slcdf_pkg::BYTE_W-1:0]      cfg_wr_data = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [slcdf_pkg::BYTE_W-1:0]      in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [slcdf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tlast;
  logic                              out_tuser;

  som_length_checksum_deframer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [7:0] data_byte
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [7:0] payload, [15:8] position, [16] sum_ok
    .out_tlast   (out_tlast),   // last body byte
    .out_tuser   (out_tuser)    // kind
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // deframer model state and its copy of the marker register
  deframe_phase_t rx_phase    = PH_IDLE;
  logic [7:0]     body_sum    = '0;
  logic [7:0]     body_count  = '0;
  logic [7:0]     body_len    = '0;
  logic [7:0]     marker_copy = slcdf_pkg::MARKER_RESET;

  slcdf_pkg::item_t pending_items[$];   // items the deframer still owes us
  int    err_count    = 0;
  int    sent_count   = 0;
  int    cycle_count  = 0;

  // idling controls, percent chance that a burst starts ahead of a source byte or on a given sink cycle
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_stall_left = 0;

  // directed table, start marker at its reset value
  dir_row_t dir_tab [DIR_ROWS] = '{
    // passthrough extremes
    '{ROW_TYPED,   8'h00, '{slcdf_pkg::KIND_PASS,  8'h00, 8'h00, 1'b0, 1'b0}},
    '{ROW_TYPED,   8'hFF, '{slcdf_pkg::KIND_PASS,  8'hFF, 8'h00, 1'b0, 1'b0}},
    '{ROW_CHECKED, 8'h7F, '0},
    '{ROW_CHECKED, 8'h80, '0},
    // three-byte frame with the marker value inside the body, sum good
    '{ROW_SILENT,  8'h02, '0},
    '{ROW_SILENT,  8'h03, '0},
    '{ROW_TYPED,   8'h10, '{slcdf_pkg::KIND_FRAME, 8'h10, 8'h00, 1'b0, 1'b0}},
    '{ROW_TYPED,   8'h02, '{slcdf_pkg::KIND_FRAME, 8'h02, 8'h01, 1'b0, 1'b0}},
    '{ROW_TYPED,   8'hEB, '{slcdf_pkg::KIND_FRAME, 8'hEB, 8'h02, 1'b1, 1'b1}},
    // marker value used as the length, sum bad
    '{ROW_SILENT,  8'h02, '0},
    '{ROW_SILENT,  8'h02, '0},
    '{ROW_TYPED,   8'h05, '{slcdf_pkg::KIND_FRAME, 8'h05, 8'h00, 1'b0, 1'b0}},
    '{ROW_TYPED,   8'h00, '{slcdf_pkg::KIND_FRAME, 8'h00, 8'h01, 1'b1, 1'b0}},
    // one-byte frames, good then bad
    '{ROW_SILENT,  8'h02, '0},
    '{ROW_SILENT,  8'h01, '0},
    '{ROW_TYPED,   8'hFF, '{slcdf_pkg::KIND_FRAME, 8'hFF, 8'h00, 1'b1, 1'b1}},
    '{ROW_SILENT,  8'h02, '0},
    '{ROW_SILENT,  8'h01, '0},
    '{ROW_TYPED,   8'h00, '{slcdf_pkg::KIND_FRAME, 8'h00, 8'h00, 1'b1, 1'b0}},
    // passthrough bit patterns and neighbors of the marker
    '{ROW_CHECKED, 8'h55, '0},
    '{ROW_CHECKED, 8'hAA, '0},
    '{ROW_CHECKED, 8'h01, '0},
    '{ROW_CHECKED, 8'h03, '0}
  };

  // one byte through the deframer model; returns 1 when it yields an item
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output slcdf_pkg::item_t res);
    res = '0;
    case (rx_phase)
      PH_LEN: begin
        body_len   = b;
        body_count = '0;
        body_sum   = b;
        rx_phase   = PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        res.kind     = slcdf_pkg::KIND_FRAME;
        res.payload  = b;
        res.position = body_count;
        body_count   = body_count + 8'd1;
        body_sum     = body_sum + b;
        // count wraps, so a zero length closes after 256 bytes
        if (body_count == body_len) begin
          res.last   = 1'b1;
          res.sum_ok = (body_sum == 8'd0);
          rx_phase   = PH_IDLE;
        end
        return 1'b1;
      end
      default: begin
        rx_phase = PH_IDLE;
        if (b == marker_copy) begin
          body_sum = '0;
          rx_phase = PH_LEN;
          return 1'b0;
        end
        res.kind    = slcdf_pkg::KIND_PASS;
        res.payload = b;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want,
             cycle_count);
    err_count++;
  endtask

  // one byte on the input stream, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input row_kind_t how = ROW_CHECKED,
                           input slcdf_pkg::item_t typed = '0);
    slcdf_pkg::item_t res;
    bit               yields;
    int               gap;
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    yields = deframe_byte(b, res);
    if (how == ROW_TYPED) pending_items.push_back(typed);
    else if (how == ROW_CHECKED && yields) pending_items.push_back(res);
    sent_count++;
  endtask

  // sender holds off until every owed item has come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    // marker or length bytes may still be in flight with nothing owed
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    marker_copy = value;
  endtask

  // marker, length, body; the last body byte forces a zero sum when good
  task automatic send_frame(input logic [7:0] len, input bit good);
    logic [7:0] sum;
    int         n;
    sum = len;
    n   = (len == 8'd0) ? 256 : int'(len);
    send_byte(marker_copy);
    send_byte(len);
    for (int i = 0; i < n - 1; i++) begin
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      sum += b;
      send_byte(b);
    end
    send_byte(good ? 8'(-sum) : 8'($urandom_range(0, 255)));
  endtask

  // feed filler until the model is back in idle, so a marker write is safe
  task automatic close_frame();
    while (rx_phase != PH_IDLE) begin
      if (rx_phase == PH_LEN) send_byte(8'($urandom_range(1, 8)));
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // mostly small lengths, now and then a long one or a zero (256 bytes)
  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 8'($urandom_range(17, 255));
    if (r == 2) return 8'd0;
    return 8'($urandom_range(1, 16));
  endfunction

  task automatic run_traffic(input int n_items, input bit mid_drain);
    int start;
    int pick;
    bit drained;
    start   = sent_count;
    drained = 1'b0;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_length(), bit'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        // noise, may itself hit the marker and open a frame
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // cut-off frame: later traffic gets swallowed as its body
        send_byte(marker_copy);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      if (mid_drain && !drained && sent_count - start > n_items / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
    close_frame();
  endtask

  // result side ready, with random stall bursts
  always @(negedge clk) begin
    if (sink_stall_left > 0) begin
      out_tready <= 1'b0;
      sink_stall_left--;
    end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      out_tready <= 1'b0;
      sink_stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker, oldest owed item first
  always @(posedge clk) begin : check_results
    slcdf_pkg::item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_items.size() == 0) begin
        report_mismatch("unexpected item, payload", out_tdata[7:0], 0);
      end else begin
        want = pending_items.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[7:0] !== want.payload)
          report_mismatch("payload", out_tdata[7:0], want.payload);
        if (out_tdata[15:8] !== want.position)
          report_mismatch("position", out_tdata[15:8], want.position);
        if (out_tlast !== want.last)
          report_mismatch("last", out_tlast, want.last);
        if (out_tdata[16] !== want.sum_ok)
          report_mismatch("sum_ok", out_tdata[16], want.sum_ok);
        if (out_tdata[slcdf_pkg::OUT_TDATA_W-1:17] !== '0)
          report_mismatch("zero fill", out_tdata[slcdf_pkg::OUT_TDATA_W-1:17], 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("som_length_checksum_deframer_top verification failed");
      $finish;
    end
  end

  logic [7:0] seg_marker [NUM_SEGS];

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, at the reset marker value
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_tab[i].data, dir_tab[i].how, dir_tab[i].want);

    // zero length runs 256 bytes up to position 255; also the longest
    // explicit length and a bad one-byte frame
    send_frame(8'd0, 1'b1);
    send_frame(8'd0, 1'b0);
    send_frame(8'd255, 1'b1);
    send_frame(8'd1, 1'b0);
    close_frame();

    // marker settings: both extremes, random values, and back to reset
    seg_marker[0] = 8'h00;
    seg_marker[1] = 8'hFF;
    seg_marker[2] = 8'($urandom_range(0, 255));
    seg_marker[3] = slcdf_pkg::MARKER_RESET;
    seg_marker[4] = 8'($urandom_range(0, 255));

    for (int s = 0; s < NUM_SEGS; s++) begin
      write_marker(seg_marker[s]);
      if (s == NUM_SEGS - 1) begin
        // closing stretch runs at full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
        sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
      end
      run_traffic(SEG_ITEMS, s == 1);
    end

    // drain, then give in-flight bytes time to show up uninvited
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("som_length_checksum_deframer_top verification clean");
    end else begin
      $display("som_length_checksum_deframer_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/slcdf_pkg.sv
rtl/core/slcdf_front.sv
rtl/core/slcdf_fifo.sv
rtl/core/slcdf_back.sv
rtl/core/som_length_checksum_deframer_top.sv
rtl/core/slcdf_chk.sv
tb/som_length_checksum_deframer_top_tb.sv
